// ===== hw/rtl/rbsi_pkg.sv =====
// rbsi_pkg: shared constants, types and register indexes for the ray/box slab test
// no dependencies
package rbsi_pkg;

  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned CW  = 32;                  // coordinate width
  localparam int unsigned QB  = CW + 1;              // quotient bits resolved by steps
  localparam int unsigned NW  = CW + 1 + COORD_FRAC_BITS; // scaled numerator width
  localparam int unsigned HW  = NW - QB;             // numerator bits above the steps
  localparam int unsigned DIV_LAT  = QB + 2;
  localparam int unsigned LANE_LAT = DIV_LAT + 1;
  localparam int unsigned TW  = CW + 2;              // slab distance incl. infinities

  localparam logic signed [TW-1:0] T_POS_INF = TW'(64'sd4294967296);
  localparam logic signed [TW-1:0] T_NEG_INF = -T_POS_INF;
  localparam logic signed [CW-1:0] S_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] S_MIN = {1'b1, {(CW-1){1'b0}}};

  localparam logic signed [1:0] NRM_POS = 2'sb01;
  localparam logic signed [1:0] NRM_NEG = 2'sb11;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [TW-1:0] lo;
    logic signed [TW-1:0] hi;
    logic                 miss;
  } slab_t;

  typedef struct packed {
    logic signed [CW-1:0] t_max;
    logic signed [CW-1:0] t_min;
    logic signed [CW-1:0] dir_z;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_x;
  } ray_t;

endpackage

// ===== hw/rtl/ray_box_slab_intersect.sv =====
// ray_box_slab_intersect: three axis lanes, merge, hit point and face selection
// depends on rbsi_pkg, rbsi_lane
// one word per cycle sustained while the output is not stalled;
// the depth is set by the one-bit-per-stage dividers in each lane (35 stages)
// a stalled output holds the whole pipeline; s_axis_tready drops only while a valid result is stalled
// reset: asynchronous, active low; clears valid state and loads the box to +-0.5
module ray_box_slab_intersect import rbsi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z, front_face, pad
  output logic [135:0] m_axis_tdata,
  // hit
  output logic         m_axis_tuser
);

  localparam int unsigned NST = LANE_LAT + 6;

  logic signed [CW-1:0] bmin_q [3];
  logic signed [CW-1:0] bmax_q [3];
  logic [NST-1:0]       vld_q;
  logic                 en;
  ray_t                 ray;
  ray_t                 sb_q [LANE_LAT];
  slab_t                slab [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        bmin_q[a] <= -CW'(32'sd32768);
        bmax_q[a] <= CW'(32'sd32768);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MIN_X: bmin_q[0] <= cfg_data_i;
        REG_MIN_Y: bmin_q[1] <= cfg_data_i;
        REG_MIN_Z: bmin_q[2] <= cfg_data_i;
        REG_MAX_X: bmax_q[0] <= cfg_data_i;
        REG_MAX_Y: bmax_q[1] <= cfg_data_i;
        REG_MAX_Z: bmax_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en            = !vld_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NST-1];
  assign ray           = ray_t'(s_axis_tdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= ray;
      for (int i = 1; i < LANE_LAT; i++) sb_q[i] <= sb_q[i-1];
    end
  end

  rbsi_lane u_lane_x (.clk_i, .en_i(en), .bmin_i(bmin_q[0]), .bmax_i(bmax_q[0]),
                      .org_i(ray.origin_x), .dir_i(ray.dir_x), .slab_o(slab[0]));
  rbsi_lane u_lane_y (.clk_i, .en_i(en), .bmin_i(bmin_q[1]), .bmax_i(bmax_q[1]),
                      .org_i(ray.origin_y), .dir_i(ray.dir_y), .slab_o(slab[1]));
  rbsi_lane u_lane_z (.clk_i, .en_i(en), .bmin_i(bmin_q[2]), .bmax_i(bmax_q[2]),
                      .org_i(ray.origin_z), .dir_i(ray.dir_z), .slab_o(slab[2]));

  // merge: entry is the largest near distance, exit the smallest far one
  logic signed [TW-1:0] ent01, ext01, ent_d, ext_d;
  logic signed [TW-1:0] ent_q, ext_q;
  logic                 miss_q;
  ray_t                 r1_q;

  assign ent01 = (slab[1].lo > slab[0].lo) ? slab[1].lo : slab[0].lo;
  assign ent_d = (slab[2].lo > ent01) ? slab[2].lo : ent01;
  assign ext01 = (slab[1].hi < slab[0].hi) ? slab[1].hi : slab[0].hi;
  assign ext_d = (slab[2].hi < ext01) ? slab[2].hi : ext01;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q  <= ent_d;
      ext_q  <= ext_d;
      miss_q <= slab[0].miss | slab[1].miss | slab[2].miss;
      r1_q   <= sb_q[LANE_LAT-1];
    end
  end

  logic                    hit2_q;
  logic signed [CW-1:0]    t2_q;
  logic signed [2*CW-1:0]  prod_q [3];
  logic signed [CW-1:0]    o2_q [3];
  logic signed [CW-1:0]    d2_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit2_q    <= !miss_q && ent_q >= TW'(r1_q.t_min) && ent_q <= TW'(r1_q.t_max)
                   && ent_q <= ext_q;
      t2_q      <= ent_q[CW-1:0];
      prod_q[0] <= $signed(ent_q[CW-1:0]) * r1_q.dir_x;
      prod_q[1] <= $signed(ent_q[CW-1:0]) * r1_q.dir_y;
      prod_q[2] <= $signed(ent_q[CW-1:0]) * r1_q.dir_z;
      o2_q[0]   <= r1_q.origin_x;
      o2_q[1]   <= r1_q.origin_y;
      o2_q[2]   <= r1_q.origin_z;
      d2_q[0]   <= r1_q.dir_x;
      d2_q[1]   <= r1_q.dir_y;
      d2_q[2]   <= r1_q.dir_z;
    end
  end

  // hit point: floor shift of the product, add origin, saturate
  logic                 hit3_q;
  logic signed [CW-1:0] t3_q;
  logic signed [CW-1:0] p3_q [3];
  logic signed [CW-1:0] d3_q [3];

  for (genvar a = 0; a < 3; a++) begin : g_pt
    logic signed [2*CW-1:0] sh;
    logic signed [2*CW:0]   sum;
    assign sh  = prod_q[a] >>> COORD_FRAC_BITS;
    assign sum = $signed({sh[2*CW-1], sh}) + (2*CW+1)'(o2_q[a]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (sum > (2*CW+1)'(S_MAX))      p3_q[a] <= S_MAX;
        else if (sum < (2*CW+1)'(S_MIN)) p3_q[a] <= S_MIN;
        else                             p3_q[a] <= sum[CW-1:0];
        d3_q[a] <= d2_q[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit3_q <= hit2_q;
      t3_q   <= t2_q;
    end
  end

  // face distances, min faces x y z then max faces x y z
  logic [CW:0]          fd_q [6];
  logic                 hit4_q;
  logic signed [CW-1:0] t4_q;
  logic signed [CW-1:0] p4_q [3];
  logic signed [CW-1:0] d4_q [3];

  for (genvar a = 0; a < 3; a++) begin : g_fd
    logic signed [CW:0] dn, dx;
    assign dn = (CW+1)'(p3_q[a]) - (CW+1)'(bmin_q[a]);
    assign dx = (CW+1)'(p3_q[a]) - (CW+1)'(bmax_q[a]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        fd_q[a]   <= dn[CW] ? (CW+1)'(-dn) : (CW+1)'(dn);
        fd_q[a+3] <= dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
        p4_q[a]   <= p3_q[a];
        d4_q[a]   <= d3_q[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit4_q <= hit3_q;
      t4_q   <= t3_q;
    end
  end

  // pairwise minimum, earlier face kept on a tie
  logic [CW:0]          pb_q [3];
  logic [2:0]           pi_q [3];
  logic                 hit5_q;
  logic signed [CW-1:0] t5_q;
  logic signed [CW-1:0] p5_q [3];
  logic signed [CW-1:0] d5_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_pair
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (fd_q[2*k+1] < fd_q[2*k]) begin
          pb_q[k] <= fd_q[2*k+1];
          pi_q[k] <= 3'(2*k+1);
        end else begin
          pb_q[k] <= fd_q[2*k];
          pi_q[k] <= 3'(2*k);
        end
        p5_q[k] <= p4_q[k];
        d5_q[k] <= d4_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit5_q <= hit4_q;
      t5_q   <= t4_q;
    end
  end

  // final selection and output word
  logic [2:0]           f01, face;
  logic [CW:0]          b01;
  logic [1:0]           ax;
  logic                 outw_pos, front;
  logic signed [CW-1:0] dsel;
  logic signed [1:0]    nrm;

  assign f01  = (pb_q[1] < pb_q[0]) ? pi_q[1] : pi_q[0];
  assign b01  = (pb_q[1] < pb_q[0]) ? pb_q[1] : pb_q[0];
  assign face = (pb_q[2] < b01) ? pi_q[2] : f01;
  assign outw_pos = face >= 3'd3;
  assign ax   = outw_pos ? 2'(face - 3'd3) : face[1:0];
  assign dsel = (ax == 2'd0) ? d5_q[0] : (ax == 2'd1) ? d5_q[1] : d5_q[2];
  assign front = outw_pos ? (dsel < 0) : (dsel > 0);
  assign nrm  = (front ~^ outw_pos) ? NRM_POS : NRM_NEG;

  logic [135:0] data_q;
  logic         hit_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit5_q;
      if (hit5_q) begin
        data_q <= {1'b0, front,
                   (ax == 2'd2) ? nrm : 2'sb00,
                   (ax == 2'd1) ? nrm : 2'sb00,
                   (ax == 2'd0) ? nrm : 2'sb00,
                   p5_q[2], p5_q[1], p5_q[0], t5_q};
      end else begin
        data_q <= '0;
      end
    end
  end

  assign m_axis_tdata = data_q;
  assign m_axis_tuser = hit_q;

endmodule

// ===== hw/rtl/rbsi_div.sv =====
// rbsi_div: pipelined restoring divider, one quotient bit per stage, saturating to 32 bits
// depends on rbsi_pkg
module rbsi_div import rbsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [CW-1:0] den_i,
  output logic signed [CW-1:0] quo_o
);

  logic [NW-1:0]   nmag;
  logic [CW-1:0]   dmag;
  logic [HW-1:0]   nhi;

  logic [CW-1:0]   rem_q  [QB+1];
  logic [QB-1:0]   wrk_q  [QB+1];
  logic [CW-1:0]   dmag_q [QB+1];
  logic            neg_q  [QB+1];
  logic            ovf_q  [QB+1];
  logic signed [CW-1:0] quo_q;

  assign nmag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign dmag = den_i[CW-1] ? CW'(-den_i) : CW'(den_i);
  assign nhi  = nmag[NW-1:QB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= CW'(nhi);
      wrk_q[0]  <= nmag[QB-1:0];
      dmag_q[0] <= dmag;
      neg_q[0]  <= num_i[NW-1] ^ den_i[CW-1];
      ovf_q[0]  <= {{(CW+1-HW){1'b0}}, nhi} >= {1'b0, dmag};
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [CW:0] trial;
    logic        ge;
    assign trial = {rem_q[i-1], wrk_q[i-1][QB-1]};
    assign ge    = trial >= {1'b0, dmag_q[i-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? CW'(trial - {1'b0, dmag_q[i-1]}) : trial[CW-1:0];
        wrk_q[i]  <= {wrk_q[i-1][QB-2:0], ge};
        dmag_q[i] <= dmag_q[i-1];
        neg_q[i]  <= neg_q[i-1];
        ovf_q[i]  <= ovf_q[i-1];
      end
    end
  end

  logic [QB-1:0] q;
  assign q = wrk_q[QB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!neg_q[QB]) begin
        quo_q <= (ovf_q[QB] || q[QB-1:CW-1] != '0) ? S_MAX : CW'(q);
      end else begin
        quo_q <= (ovf_q[QB] || q > {2'b01, {(CW-1){1'b0}}}) ? S_MIN : CW'(-q);
      end
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== hw/rtl/rbsi_lane.sv =====
// rbsi_lane: one axis of the slab test, two plane distances and their ordering
// depends on rbsi_pkg, rbsi_div
module rbsi_lane import rbsi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] bmin_i,
  input  logic signed [CW-1:0] bmax_i,
  input  logic signed [CW-1:0] org_i,
  input  logic signed [CW-1:0] dir_i,
  output slab_t                slab_o
);

  logic signed [CW:0]   dmin, dmax;
  logic signed [NW-1:0] nmin, nmax;
  logic signed [CW-1:0] t0, t1;
  logic                 zero_q [DIV_LAT];
  logic                 out_q  [DIV_LAT];
  slab_t                slab_q;

  assign dmin = $signed({bmin_i[CW-1], bmin_i}) - $signed({org_i[CW-1], org_i});
  assign dmax = $signed({bmax_i[CW-1], bmax_i}) - $signed({org_i[CW-1], org_i});
  assign nmin = {dmin, {COORD_FRAC_BITS{1'b0}}};
  assign nmax = {dmax, {COORD_FRAC_BITS{1'b0}}};

  rbsi_div u_div_min (.clk_i, .en_i, .num_i(nmin), .den_i(dir_i), .quo_o(t0));
  rbsi_div u_div_max (.clk_i, .en_i, .num_i(nmax), .den_i(dir_i), .quo_o(t1));

  // zero-direction and outside-slab flags ride alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= dir_i == '0;
      out_q[0]  <= !(bmin_i <= org_i && org_i <= bmax_i);
      for (int i = 1; i < DIV_LAT; i++) begin
        zero_q[i] <= zero_q[i-1];
        out_q[i]  <= out_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (zero_q[DIV_LAT-1]) begin
        slab_q.lo   <= T_NEG_INF;
        slab_q.hi   <= T_POS_INF;
        slab_q.miss <= out_q[DIV_LAT-1];
      end else begin
        slab_q.lo   <= TW'((t0 < t1) ? t0 : t1);
        slab_q.hi   <= TW'((t0 < t1) ? t1 : t0);
        slab_q.miss <= 1'b0;
      end
    end
  end

  assign slab_o = slab_q;

endmodule

// ===== hw/rtl/rbsi_checker.sv =====
// rbsi_checker: port-level checks on the result stream, bound to the top level
// depends on ray_box_slab_intersect
module rbsi_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss word not cleared");

  a_one_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      $countones({m_axis_tdata[129:128] != 2'b00, m_axis_tdata[131:130] != 2'b00,
                  m_axis_tdata[133:132] != 2'b00}) == 1)
    else $error("normal not on exactly one axis");

  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[129:128] != 2'b10 && m_axis_tdata[131:130] != 2'b10
                      && m_axis_tdata[133:132] != 2'b10 && !m_axis_tdata[135])
    else $error("normal component out of range");

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

// ===== sim/testbench.sv =====
// testbench for ray_box_slab_intersect: directed and random rays against a configurable box
// depends on rbsi_pkg and the ray_box_slab_intersect rtl
`timescale 1ns / 1ps

module testbench import rbsi_pkg::*;;

  typedef struct {
    bit               hit;
    bit signed [31:0] hit_t, px, py, pz;
    bit signed [1:0]  nx, ny, nz;
    bit               front;
  } hit_rec_t;

  class hit_scoreboard;
    longint box_lo[3], box_hi[3];
    hit_rec_t pending[$];
    int errors;

    function new();
      foreach (box_lo[a]) begin
        box_lo[a] = -32768;
        box_hi[a] = 32768;
      end
      errors = 0;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void set_box(reg_idx_e idx, bit [31:0] v);
      if (idx < REG_MAX_X) box_lo[idx] = longint'(signed'(v));
      else box_hi[idx - 3] = longint'(signed'(v));
    endfunction

    // work out the intersection for one accepted ray word
    function void note_ray(bit [255:0] w);
      longint o[3], d[3], p[3], lo, hi, t0, t1, entry, leave, tmin, tmax, best, fdist;
      longint inf;
      int face, ax;
      bit miss, front;
      hit_rec_t r;
      inf = 64'sd1 << 40;
      for (int a = 0; a < 3; a++) begin
        o[a] = longint'(signed'(w[32*a +: 32]));
        d[a] = longint'(signed'(w[32*(a+3) +: 32]));
      end
      tmin = longint'(signed'(w[192 +: 32]));
      tmax = longint'(signed'(w[224 +: 32]));
      entry = -inf;
      leave = inf;
      miss = 0;
      for (int a = 0; a < 3; a++) begin
        if (d[a] == 0) begin
          if (!(box_lo[a] <= o[a] && o[a] <= box_hi[a])) miss = 1;
          lo = -inf;
          hi = inf;
        end else begin
          t0 = clamp32(((box_lo[a] - o[a]) * 65536) / d[a]);
          t1 = clamp32(((box_hi[a] - o[a]) * 65536) / d[a]);
          lo = t0 < t1 ? t0 : t1;
          hi = t0 < t1 ? t1 : t0;
        end
        if (lo > entry) entry = lo;
        if (hi < leave) leave = hi;
      end
      r = '{default: 0};
      if (!(miss || entry < tmin || entry > tmax || entry > leave)) begin
        // >>> on a signed longint floors toward minus infinity
        for (int a = 0; a < 3; a++) p[a] = clamp32(o[a] + ((entry * d[a]) >>> 16));
        face = 0;
        best = p[0] - box_lo[0];
        if (best < 0) best = -best;
        for (int k = 1; k < 6; k++) begin
          fdist = k < 3 ? p[k] - box_lo[k] : p[k-3] - box_hi[k-3];
          if (fdist < 0) fdist = -fdist;
          if (fdist < best) begin
            best = fdist;
            face = k;
          end
        end
        ax = face % 3;
        front = face < 3 ? d[ax] > 0 : d[ax] < 0;
        r.hit = 1;
        r.hit_t = entry[31:0];
        r.px = p[0][31:0];
        r.py = p[1][31:0];
        r.pz = p[2][31:0];
        if (ax == 0) r.nx = ((face < 3) ^ front) ? NRM_POS : NRM_NEG;
        if (ax == 1) r.ny = ((face < 3) ^ front) ? NRM_POS : NRM_NEG;
        if (ax == 2) r.nz = ((face < 3) ^ front) ? NRM_POS : NRM_NEG;
        r.front = front;
      end
      pending.push_back(r);
    endfunction

    function void cmp(string name, longint e, longint g);
      if (e != g) begin
        $error("%s: expected %0d, got %0d", name, e, g);
        errors++;
      end
    endfunction

    function void check_hit(bit user, bit [135:0] w);
      hit_rec_t e;
      if (pending.size() == 0) begin
        $error("result word with no ray outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      cmp("hit", e.hit, user);
      cmp("hit_t", e.hit_t, signed'(w[31:0]));
      cmp("point_x", e.px, signed'(w[63:32]));
      cmp("point_y", e.py, signed'(w[95:64]));
      cmp("point_z", e.pz, signed'(w[127:96]));
      cmp("normal_x", e.nx, signed'(w[129:128]));
      cmp("normal_y", e.ny, signed'(w[131:130]));
      cmp("normal_z", e.nz, signed'(w[133:132]));
      cmp("front_face", e.front, w[134]);
    endfunction
  endclass

  logic         clk_i = 0, rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [2:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 0, s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic         m_axis_tvalid, m_axis_tready = 0, m_axis_tuser;
  logic [135:0] m_axis_tdata;

  hit_scoreboard sb = new();
  longint cycles = 0;
  bit stall_on = 1;

  ray_box_slab_intersect DUT (.*);

  initial forever #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random back-pressure and checking
  initial begin
    int gap;
    forever begin
      gap = stall_on ? $urandom_range(0, 13) : 0;
      if ($urandom_range(0, 5) == 0) gap = 0;
      if (gap > 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_hit(m_axis_tuser, m_axis_tdata);
    end
  end

  function automatic bit [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7fff_fffc | $urandom_range(0, 3);
      3: return 0;
      default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endcase
  endfunction

  task automatic send_ray(bit signed [31:0] ox, oy, oz, dx, dy, dz, tn, tx, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {tx, tn, dz, dy, dx, oz, oy, ox};
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_ray({tx, tn, dz, dy, dx, oz, oy, ox});
  endtask

  task automatic random_ray(int gap);
    bit signed [31:0] o[3], d[3], tn, tx;
    for (int a = 0; a < 3; a++) begin
      if ($urandom_range(0, 3) != 0) begin
        // aim roughly at the box so most rays get past the slab test
        o[a] = 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16));
        d[a] = 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
        if ($urandom_range(0, 7) == 0) d[a] = 0;
      end else begin
        o[a] = rnd_coord();
        d[a] = rnd_coord();
      end
    end
    tn = $urandom_range(0, 3) == 0 ? rnd_coord() : 32'sh8000_0000 + $urandom_range(0, 1);
    tx = $urandom_range(0, 3) == 0 ? rnd_coord() : 32'sh7fff_ffff - $urandom_range(0, 1);
    if ($urandom_range(0, 2) == 0) tn = 0;
    send_ray(o[0], o[1], o[2], d[0], d[1], d[2], tn, tx, gap);
  endtask

  task automatic write_box(reg_idx_e idx, bit [31:0] v);
    cfg_we_i <= 1;
    cfg_addr_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.set_box(idx, v);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    bit signed [31:0] mx, mn;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed rays against the reset box
    send_ray(-(2 << 16), 0, 0, 1 << 16, 0, 0, mn, mx, 0);       // front hit on min x
    send_ray(2 << 16, 0, 0, -(1 << 16), 0, 0, mn, mx, 0);       // front hit on max x
    send_ray(0, 0, 0, 0, 1 << 16, 0, mn, mx, 0);                // origin inside, front face on min y
    send_ray(0, 0, 0, 0, 0, 0, mn, mx, 0);                      // all-zero direction
    send_ray(2 << 16, 0, 0, 0, 1 << 16, 0, mn, mx, 1);          // zero dir outside slab
    send_ray(32768, -(2 << 16), 0, 0, 1 << 16, 0, mn, mx, 0);   // origin on plane, zero dir
    send_ray(-(2 << 16), -(2 << 16), 0, 1 << 16, 1 << 16, 0, mn, mx, 0); // edge tie
    send_ray(-(2 << 16), 0, 0, 1 << 16, 0, 0, 2 << 16, mx, 0);  // entry below window
    send_ray(-(2 << 16), 0, 0, 1 << 16, 0, 0, mn, 1 << 16, 0);  // entry above window
    send_ray(-(2 << 16), 0, 0, 1 << 16, 0, 0, 98304, 98304, 0); // entry exactly on bounds
    send_ray(mn, mn, mn, 1, 1, 1, mn, mx, 0);                   // saturating quotient
    send_ray(mx, mx, mx, mn, mn, mn, mn, mx, 0);
    send_ray(mn, 0, 0, mx, 0, 0, mn, mx, 2);
    send_ray(-(2 << 16), 0, 0, 1 << 16, 3 << 16, 0, mn, mx, 0); // slabs disjoint
    send_ray(0, 0, -(2 << 16), 0, 0, 1 << 16, mn, mx, 0);
    send_ray(0, 0, 2 << 16, 0, 0, -1, mn, mx, 0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin // inverted box
          for (int r = 0; r < 3; r++) write_box(reg_idx_e'(r), 2 << 16);
          for (int r = 3; r < 6; r++) write_box(reg_idx_e'(r), -(2 << 16));
        end
        2: begin // extremes
          for (int r = 0; r < 3; r++) write_box(reg_idx_e'(r), mn);
          for (int r = 3; r < 6; r++) write_box(reg_idx_e'(r), mx);
        end
        3: begin // degenerate flat box
          for (int r = 0; r < 6; r++)
            write_box(reg_idx_e'(r), r == 1 || r == 4 ? 0 : (r < 3 ? -(3 << 16) : 3 << 16));
        end
        4: for (int r = 0; r < 6; r++) write_box(reg_idx_e'(r), rnd_coord());
        5: for (int r = 0; r < 6; r++)
             write_box(reg_idx_e'(r),
                       r < 3 ? -($urandom_range(1, 6) << 16) : $urandom_range(1, 6) << 16);
        default: ;
      endcase
      cfg_we_i <= 0;
      stall_on = phase != 3;
      for (int i = 0; i < 300; i++)
        random_ray(phase == 3 || $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 13));
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/rbsi_pkg.sv
hw/rtl/rbsi_div.sv
hw/rtl/rbsi_lane.sv
hw/rtl/ray_box_slab_intersect.sv
hw/rtl/rbsi_checker.sv
sim/testbench.sv
